FILE: hdl/rvq_pkg.sv
package rvq_pkg;

	// CORDIC micro-rotations, one cell each (at most 32).
	localparam int ITER = 24;
	// Width of the CORDIC x, y and z words.
	localparam int CW = 34;

	localparam logic signed [34:0] PI_Q30    = 35'sd3373259426;
	localparam logic signed [34:0] TWOPI_Q30 = 35'sd6746518852;
	localparam logic signed [34:0] HPI_Q30   = 35'sd1686629713;
	localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
	localparam logic signed [23:0] Q_ONE22 = 24'sd4194304;

	typedef logic signed [23:0] comp_t;

	typedef struct packed {
		logic [47:0] n;
		logic [25:0] rem;
		logic [23:0] root;
		comp_t vx;
		comp_t vy;
		comp_t vz;
	} sqrt_bus_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic neg;
		logic [23:0] angle;
		logic [43:0] x3;
		comp_t vx;
		comp_t vy;
		comp_t vz;
	} cor_bus_t;

	typedef struct packed {
		logic [2:0][31:0] rem;
		logic [2:0][23:0] quo;
		logic [31:0] den;
		logic [47:0] x3;
		logic [47:0] q3;
		logic [1:0] r3;
		logic [23:0] angle;
		comp_t w;
		comp_t vx;
		comp_t vy;
		comp_t vz;
		logic s_neg;
	} div_bus_t;

	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] a;
		case (i)
			5'd0: a = 32'd843314857;
			5'd1: a = 32'd497837829;
			5'd2: a = 32'd263043837;
			5'd3: a = 32'd133525159;
			5'd4: a = 32'd67021687;
			5'd5: a = 32'd33543516;
			5'd6: a = 32'd16775851;
			5'd7: a = 32'd8388437;
			5'd8: a = 32'd4194283;
			5'd9: a = 32'd2097149;
			5'd10: a = 32'd1048576;
			5'd11: a = 32'd524288;
			5'd12: a = 32'd262144;
			5'd13: a = 32'd131072;
			5'd14: a = 32'd65536;
			5'd15: a = 32'd32768;
			5'd16: a = 32'd16384;
			5'd17: a = 32'd8192;
			5'd18: a = 32'd4096;
			5'd19: a = 32'd2048;
			5'd20: a = 32'd1024;
			5'd21: a = 32'd512;
			5'd22: a = 32'd256;
			5'd23: a = 32'd128;
			5'd24: a = 32'd64;
			5'd25: a = 32'd32;
			5'd26: a = 32'd16;
			5'd27: a = 32'd8;
			5'd28: a = 32'd4;
			5'd29: a = 32'd2;
			5'd30: a = 32'd1;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

	function automatic comp_t sat22(input logic signed [63:0] v);
		comp_t r;
		if (v > 64'sd4194304)
			r = Q_ONE22;
		else if (v < -64'sd4194304)
			r = -Q_ONE22;
		else
			r = 24'(v);
		return r;
	endfunction

endpackage

FILE: hdl/rvq_sqrt_cell.sv
module rvq_sqrt_cell import rvq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      vld_in,
	input  sqrt_bus_t d,
	output logic      vld_out,
	output sqrt_bus_t q
);

	logic [27:0] sh;
	logic [27:0] trial;
	sqrt_bus_t nx;

	assign sh = {d.rem, d.n[47:46]};
	assign trial = {2'b00, d.root, 2'b01};

	// One root bit per cell: two radicand bits enter the partial remainder.
	always_comb begin
		nx = d;
		nx.n = {d.n[45:0], 2'b00};
		if (sh >= trial) begin
			nx.rem = 26'(sh - trial);
			nx.root = {d.root[22:0], 1'b1};
		end else begin
			nx.rem = sh[25:0];
			nx.root = {d.root[22:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_out <= 1'b0;
		else if (en)
			vld_out <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en)
			q <= nx;
	end

endmodule

FILE: hdl/rvq_cordic_cell.sv
module rvq_cordic_cell import rvq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [4:0] step,
	input  logic       vld_in,
	input  cor_bus_t   d,
	output logic       vld_out,
	output cor_bus_t   q
);

	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;
	logic signed [CW-1:0] at;
	cor_bus_t nx;

	assign dx = d.y >>> step;
	assign dy = d.x >>> step;
	assign at = signed'({2'b00, atan_q30(step)});

	always_comb begin
		nx = d;
		if (!d.z[CW-1]) begin
			nx.x = d.x - dx;
			nx.y = d.y + dy;
			nx.z = d.z - at;
		end else begin
			nx.x = d.x + dx;
			nx.y = d.y - dy;
			nx.z = d.z + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_out <= 1'b0;
		else if (en)
			vld_out <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en)
			q <= nx;
	end

endmodule

FILE: hdl/rvq_div_cell.sv
module rvq_div_cell import rvq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     vld_in,
	input  div_bus_t d,
	output logic     vld_out,
	output div_bus_t q
);

	div_bus_t nx;
	logic [32:0] sh;
	logic [2:0] t1;
	logic [2:0] t2;
	logic [1:0] r1;
	logic [1:0] r2;
	logic qa;
	logic qb;

	// Three restoring-division lanes give one quotient bit each, and the
	// divide-by-three lane takes two bits of the dividend.
	always_comb begin
		nx = d;
		sh = '0;
		for (int k = 0; k < 3; k++) begin
			sh = {d.rem[k], d.quo[k][23]};
			if (sh >= {1'b0, d.den}) begin
				nx.rem[k] = 32'(sh - {1'b0, d.den});
				nx.quo[k] = {d.quo[k][22:0], 1'b1};
			end else begin
				nx.rem[k] = sh[31:0];
				nx.quo[k] = {d.quo[k][22:0], 1'b0};
			end
		end
		t1 = {d.r3, d.x3[47]};
		qa = (t1 >= 3'd3);
		r1 = qa ? 2'(t1 - 3'd3) : t1[1:0];
		t2 = {r1, d.x3[46]};
		qb = (t2 >= 3'd3);
		r2 = qb ? 2'(t2 - 3'd3) : t2[1:0];
		nx.r3 = r2;
		nx.x3 = {d.x3[45:0], 2'b00};
		nx.q3 = {d.q3[45:0], qa, qb};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_out <= 1'b0;
		else if (en)
			vld_out <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en)
			q <= nx;
	end

endmodule

FILE: hdl/rotation_vector_to_quaternion.sv
// Channel   Signals                                   Direction
// input     in_valid, in_ready, rot_x/y/z             into the block
// result    out_valid, out_ready, quat_w/x/y/z        out of the block
// config    cfg_valid, cfg_ready, small_angle_limit   into the block
//
// One item enters per clock while in_ready is high; it passes s1, s2, square-root
// cells, s3, CORDIC cells, s4, division cells, s5 and s6 to the result register.
// Reset clears the valid flags and sets the limit to 1; config is always ready.
// The whole pipeline stalls only when the result register is held and the
// last stage carries an item; otherwise it keeps moving and accepting.
module rotation_vector_to_quaternion import rvq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  comp_t       rot_x,
	input  comp_t       rot_y,
	input  comp_t       rot_z,
	output logic        out_valid,
	input  logic        out_ready,
	output comp_t       quat_w,
	output comp_t       quat_x,
	output comp_t       quat_y,
	output comp_t       quat_z,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [22:0] small_angle_limit
);

	logic en;
	logic out_load;
	logic [22:0] limit_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	comp_t vx_s1, vy_s1, vz_s1;

	sqrt_bus_t sq_s2;
	sqrt_bus_t sq_c [0:24];
	logic vld_sq [0:24];

	cor_bus_t co_s3;
	cor_bus_t co_c [0:ITER];
	logic vld_co [0:ITER];

	div_bus_t dv_s4;
	div_bus_t dv_c [0:24];
	logic vld_dv [0:24];

	assign en = !out_valid || out_ready || !vld_s6;
	assign out_load = !out_valid || out_ready;
	assign in_ready = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= 23'd1;
		else if (cfg_valid)
			limit_q <= small_angle_limit;
	end

	// Valid flags of the stages outside the cell rows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en) begin
				vld_s1 <= in_valid;
				vld_s2 <= vld_s1;
				vld_s3 <= vld_sq[24];
				vld_s4 <= vld_co[ITER];
				vld_s5 <= vld_dv[24];
				vld_s6 <= vld_s5;
			end
			if (out_load)
				out_valid <= vld_s6;
		end
	end

	// Input capture and sum of squares.
	logic signed [47:0] px, py, pz;
	assign px = 48'(vx_s1) * 48'(vx_s1);
	assign py = 48'(vy_s1) * 48'(vy_s1);
	assign pz = 48'(vz_s1) * 48'(vz_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s1 <= rot_x;
			vy_s1 <= rot_y;
			vz_s1 <= rot_z;
			sq_s2.n <= 48'(px) + 48'(py) + 48'(pz);
			sq_s2.rem <= '0;
			sq_s2.root <= '0;
			sq_s2.vx <= vx_s1;
			sq_s2.vy <= vy_s1;
			sq_s2.vz <= vz_s1;
		end
	end

	assign sq_c[0] = sq_s2;
	assign vld_sq[0] = vld_s2;

	for (genvar i = 0; i < 24; i++) begin : g_sqrt
		rvq_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_in  (vld_sq[i]),
			.d       (sq_c[i]),
			.vld_out (vld_sq[i+1]),
			.q       (sq_c[i+1])
		);
	end

	// Range reduction of the half angle, and the Taylor dividend.
	logic [23:0] ang;
	logic signed [34:0] r0, r1, r2, r3;
	logic neg3;
	logic [47:0] asq;
	logic [48:0] asq_b;

	assign ang = sq_c[24].root;
	assign asq = 48'(ang) * 48'(ang);
	assign asq_b = 49'(asq) + 49'd24;

	always_comb begin
		r0 = signed'({2'b00, ang, 9'd0});
		r1 = (r0 > PI_Q30) ? r0 - TWOPI_Q30 : r0;
		r2 = (r1 > PI_Q30) ? r1 - TWOPI_Q30 : r1;
		neg3 = 1'b0;
		r3 = r2;
		if (r2 > HPI_Q30) begin
			r3 = r2 - PI_Q30;
			neg3 = 1'b1;
		end else if (r2 < -HPI_Q30) begin
			r3 = r2 + PI_Q30;
			neg3 = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			co_s3.x <= GAIN_Q30;
			co_s3.y <= '0;
			co_s3.z <= CW'(r3);
			co_s3.neg <= neg3;
			co_s3.angle <= ang;
			co_s3.x3 <= asq_b[47:4];
			co_s3.vx <= sq_c[24].vx;
			co_s3.vy <= sq_c[24].vy;
			co_s3.vz <= sq_c[24].vz;
		end
	end

	assign co_c[0] = co_s3;
	assign vld_co[0] = vld_s3;

	for (genvar i = 0; i < ITER; i++) begin : g_cordic
		rvq_cordic_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.step    (5'(i)),
			.vld_in  (vld_co[i]),
			.d       (co_c[i]),
			.vld_out (vld_co[i+1]),
			.q       (co_c[i+1])
		);
	end

	// Cosine output, sine magnitude and the three dividends.
	cor_bus_t co_e;
	logic signed [CW-1:0] cval;
	logic signed [CW:0] cr;
	logic [CW-1:0] ya;
	logic [31:0] smag;
	logic s_neg4;
	logic [23:0] vm [3];
	logic [55:0] num [3];
	comp_t vin [3];

	assign co_e = co_c[ITER];
	assign cval = co_e.neg ? -co_e.x : co_e.x;
	assign cr = (CW+1)'(cval) + (CW+1)'(128);
	assign ya = co_e.y[CW-1] ? CW'(-co_e.y) : CW'(co_e.y);
	assign smag = ya[31:0];
	assign s_neg4 = co_e.neg ? (co_e.y > 0) : (co_e.y < 0);
	assign vin[0] = co_e.vx;
	assign vin[1] = co_e.vy;
	assign vin[2] = co_e.vz;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			vm[k] = vin[k][23] ? 24'(-vin[k]) : 24'(vin[k]);
			num[k] = 56'(vm[k]) * 56'(smag) + 56'({co_e.angle, 7'd0});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				dv_s4.rem[k] <= num[k][55:24];
				dv_s4.quo[k] <= num[k][23:0];
			end
			dv_s4.den <= {co_e.angle, 8'd0};
			dv_s4.x3 <= {4'd0, co_e.x3};
			dv_s4.q3 <= '0;
			dv_s4.r3 <= '0;
			dv_s4.angle <= co_e.angle;
			dv_s4.w <= sat22(64'(cr >>> 8));
			dv_s4.vx <= co_e.vx;
			dv_s4.vy <= co_e.vy;
			dv_s4.vz <= co_e.vz;
			dv_s4.s_neg <= s_neg4;
		end
	end

	assign dv_c[0] = dv_s4;
	assign vld_dv[0] = vld_s4;

	for (genvar i = 0; i < 24; i++) begin : g_div
		rvq_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_in  (vld_dv[i]),
			.d       (dv_c[i]),
			.vld_out (vld_dv[i+1]),
			.q       (dv_c[i+1])
		);
	end

	// Taylor factor in Q30, then its products with the vector.
	div_bus_t dv_e;
	logic signed [45:0] f40;
	logic signed [45:0] f40r;

	assign dv_e = dv_c[24];
	assign f40 = 46'sd549755813888 - signed'({2'b00, dv_e.q3[43:0]});
	assign f40r = f40 + 46'sd512;

	logic signed [35:0] f30_s5;
	logic [2:0][23:0] quo_s5, quo_s6;
	comp_t w_s5, w_s6;
	comp_t v_s5 [3];
	comp_t v_s6 [3];
	logic [23:0] angle_s5, angle_s6;
	logic sneg_s5, sneg_s6;
	logic signed [59:0] prod_s6 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			f30_s5 <= 36'(f40r >>> 10);
			quo_s5 <= dv_e.quo;
			w_s5 <= dv_e.w;
			v_s5[0] <= dv_e.vx;
			v_s5[1] <= dv_e.vy;
			v_s5[2] <= dv_e.vz;
			angle_s5 <= dv_e.angle;
			sneg_s5 <= dv_e.s_neg;
			for (int k = 0; k < 3; k++) begin
				prod_s6[k] <= 60'(v_s5[k]) * 60'(f30_s5);
				v_s6[k] <= v_s5[k];
			end
			quo_s6 <= quo_s5;
			w_s6 <= w_s5;
			angle_s6 <= angle_s5;
			sneg_s6 <= sneg_s5;
		end
	end

	// Final selection between the full and the Taylor vector part.
	logic full6;
	comp_t qv [3];
	comp_t res [3];
	logic signed [59:0] pr_r [3];

	assign full6 = angle_s6 > {1'b0, limit_q};

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			qv[k] = (quo_s6[k] > 24'(Q_ONE22)) ? Q_ONE22 : signed'(quo_s6[k]);
			pr_r[k] = prod_s6[k] + 60'sd134217728;
			if (full6)
				res[k] = (v_s6[k][23] != sneg_s6) ? -qv[k] : qv[k];
			else
				res[k] = sat22(64'(pr_r[k] >>> 28));
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			quat_w <= w_s6;
			quat_x <= res[0];
			quat_y <= res[1];
			quat_z <= res[2];
		end
	end

	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready && vld_s6))
		else $error("input stalled without a blocked result");

	a_w_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (quat_w <= Q_ONE22 && quat_w >= -Q_ONE22))
		else $error("quat_w outside the unit range");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !vld_s6) |=> !out_valid)
		else $error("result appeared from an empty last stage");

endmodule
